/* src/tcwc_pkg.sv */
// Package for the TCP congestion window engine: codes, types and helpers.
package tcwc_pkg;

  localparam int unsigned DupAckLimitDef = 3;
  localparam int unsigned DivW           = 32;
  localparam int unsigned CfgW           = 32;

  localparam logic [15:0] SegSizeRst  = 16'd1400;
  localparam logic [31:0] InitWinRst  = 32'd1400;

  // configuration register indexes
  localparam logic CFG_SEGMENT_SIZE   = 1'b0;
  localparam logic CFG_INITIAL_WINDOW = 1'b1;

  typedef enum logic [1:0] {
    MODE_OPEN    = 2'd0,
    MODE_BURST   = 2'd1,
    MODE_ACK     = 2'd2,
    MODE_TIMEOUT = 2'd3
  } tcwc_mode_e;

  typedef enum logic [2:0] {
    ST_OPENED    = 3'd0,
    ST_BURST     = 3'd1,
    ST_CLOSED    = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_DUPLICATE = 3'd4,
    ST_NEW_ACK   = 3'd5,
    ST_FAST_RETX = 3'd6,
    ST_TIMEOUT   = 3'd7
  } tcwc_status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_DIV_CHUNK,
    FSM_GROW_MUL,
    FSM_DIV_GROW
  } tcwc_fsm_e;

  // request into the shared divider
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } tcwc_div_req_t;

  // answer from the shared divider
  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } tcwc_div_rsp_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

/* src/tcwc_ifs.sv */
// Event and result channel interfaces of the congestion window engine.
interface tcwc_ev_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] seq_start;
  logic [31:0] remaining_bytes;
  logic [31:0] ack_value;
  logic [15:0] adv_window;
  logic        checksum_ok;

  modport source (output valid, mode, seq_start, remaining_bytes, ack_value, adv_window,
                  checksum_ok, input ready);
  modport sink   (input valid, mode, seq_start, remaining_bytes, ack_value, adv_window,
                  checksum_ok, output ready);
endinterface

interface tcwc_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] burst_bytes;
  logic [15:0] burst_chunks;
  logic [31:0] acked_total;
  logic        burst_done;
  logic        retransmit;
  logic [31:0] resend_seq;
  logic [31:0] cong_window;
  logic [31:0] slow_start_threshold;
  logic [15:0] peer_window_out;

  modport source (output valid, status, burst_bytes, burst_chunks, acked_total, burst_done,
                  retransmit, resend_seq, cong_window, slow_start_threshold,
                  peer_window_out, input ready);
  modport sink   (input valid, status, burst_bytes, burst_chunks, acked_total, burst_done,
                  retransmit, resend_seq, cong_window, slow_start_threshold,
                  peer_window_out, output ready);
endinterface

/* src/tcwc_div.sv */
// Restoring divider, one quotient bit per cycle.
module tcwc_div
  import tcwc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tcwc_div_req_t req_i,
  output tcwc_div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DivW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] dvd_q, dvd_d;
  logic [DivW-1:0] dvs_q, dvs_d;
  logic [DivW:0]   trial;
  logic            fits;

  assign trial = {rem_q, dvd_q[DivW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? DivW'(trial - {1'b0, dvs_q}) : trial[DivW-1:0];
      dvd_d = {dvd_q[DivW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

/* src/tcp_congestion_window_control_top.sv */
// Sequencing: open, closed window, ignored/duplicate ACK, timeout, fast retransmit and
//   slow-start ACK give a registered result in the cycle after the transaction; a burst
//   start and an avoidance ACK wait on the shared 32-step divider plus sequencing.
// Flow: one transaction at a time; no new event is taken while the divider is in use.
// Reset: asynchronous, active low; clears the window state and restores the
//   segment size and initial window registers to 1400.
module tcp_congestion_window_control_top
  import tcwc_pkg::*;
#(
  parameter int unsigned DUP_ACK_LIMIT = DupAckLimitDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  tcwc_ev_if.sink         ev_i,
  tcwc_res_if.source      res_o
);

  typedef struct packed {
    tcwc_status_e status;
    logic [15:0]  burst_bytes;
    logic [15:0]  burst_chunks;
    logic [31:0]  acked_total;
    logic         burst_done;
    logic         retransmit;
    logic [31:0]  resend_seq;
    logic [31:0]  cong_window;
    logic [31:0]  ssthresh;
    logic [15:0]  peer_window;
  } res_t;

  // configuration
  logic [15:0] seg_q;
  logic [31:0] iw_q;

  // window state
  logic [31:0] cwnd_q, cwnd_d;
  logic [31:0] ssth_q, ssth_d;
  logic [15:0] peer_q, peer_d;
  logic [1:0]  dup_q, dup_d;
  logic [31:0] bseq_q, bseq_d;
  logic [15:0] blen_q, blen_d;
  logic [31:0] acked_q, acked_d;

  // sequencer and pending work
  tcwc_fsm_e   fsm_q, fsm_d;
  logic [15:0] bbytes_q, bbytes_d;
  logic [31:0] prod_q, prod_d;

  // result register
  logic res_valid_q, res_valid_d;
  res_t res_q, res_d;

  tcwc_div_req_t div_req;
  tcwc_div_rsp_t div_rsp;

  logic         accept;
  logic [15:0]  mss;
  logic [15:0]  win;
  logic [15:0]  bbytes;
  logic [16:0]  chunk_num;
  logic [31:0]  expect_ack;
  logic [1:0]   dup_inc;
  logic [31:0]  half_cwnd;
  logic         res_load;
  tcwc_status_e status_c;
  logic [15:0]  rbytes_c;
  logic [15:0]  rchunks_c;
  logic         retx_c;

  assign mss = (seg_q == 16'd0) ? 16'd1 : seg_q;

  // usable window never exceeds the 16-bit peer window
  assign win    = (cwnd_q < {16'd0, peer_q}) ? cwnd_q[15:0] : peer_q;
  assign bbytes = ({16'd0, win} < ev_i.remaining_bytes) ? win : ev_i.remaining_bytes[15:0];
  assign chunk_num  = {1'b0, bbytes} + {1'b0, mss} - 17'd1;
  assign expect_ack = bseq_q + acked_q;
  assign dup_inc    = dup_q + 2'd1;
  assign half_cwnd  = {1'b0, cwnd_q[31:1]};

  // ready only when idle and the result register is free (or draining now)
  assign ev_i.ready = (fsm_q == FSM_IDLE) && (!res_valid_q || res_o.ready);
  assign accept     = ev_i.valid && ev_i.ready;

  always_comb begin
    cwnd_d    = cwnd_q;
    ssth_d    = ssth_q;
    peer_d    = peer_q;
    dup_d     = dup_q;
    bseq_d    = bseq_q;
    blen_d    = blen_q;
    acked_d   = acked_q;
    fsm_d     = fsm_q;
    bbytes_d  = bbytes_q;
    prod_d    = prod_q;
    res_load  = 1'b0;
    status_c  = ST_IGNORED;
    rbytes_c  = '0;
    rchunks_c = '0;
    retx_c    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {15'd0, chunk_num};
    div_req.divisor  = {16'd0, mss};

    case (fsm_q)
      FSM_IDLE: begin
        if (accept) begin
          case (tcwc_mode_e'(ev_i.mode))
            MODE_OPEN: begin
              cwnd_d   = iw_q;
              peer_d   = ev_i.adv_window;
              ssth_d   = {16'd0, ev_i.adv_window};
              dup_d    = '0;
              bseq_d   = '0;
              blen_d   = '0;
              acked_d  = '0;
              status_c = ST_OPENED;
              res_load = 1'b1;
            end
            MODE_BURST: begin
              if (win == 16'd0) begin
                status_c = ST_CLOSED;
                res_load = 1'b1;
              end else begin
                // chunk count comes from the divider
                bseq_d        = ev_i.seq_start;
                blen_d        = bbytes;
                acked_d       = '0;
                bbytes_d      = bbytes;
                div_req.start = 1'b1;
                fsm_d         = FSM_DIV_CHUNK;
              end
            end
            MODE_ACK: begin
              if (!ev_i.checksum_ok) begin
                status_c = ST_IGNORED;
                res_load = 1'b1;
              end else if (ev_i.ack_value == expect_ack) begin
                if (dup_inc >= 2'(DUP_ACK_LIMIT)) begin
                  ssth_d   = half_cwnd;
                  cwnd_d   = sat_add(half_cwnd, {16'd0, mss});
                  dup_d    = '0;
                  acked_d  = '0;
                  retx_c   = 1'b1;
                  status_c = ST_FAST_RETX;
                end else begin
                  dup_d    = dup_inc;
                  status_c = ST_DUPLICATE;
                end
                res_load = 1'b1;
              end else if (ev_i.ack_value > bseq_q) begin
                dup_d   = '0;
                acked_d = ev_i.ack_value - bseq_q;
                peer_d  = ev_i.adv_window;
                if ((cwnd_q < ssth_q) || (cwnd_q == 32'd0)) begin
                  // slow start, or an empty window that cannot be divided by
                  cwnd_d   = sat_add(cwnd_q, {16'd0, mss});
                  status_c = ST_NEW_ACK;
                  res_load = 1'b1;
                end else begin
                  // avoidance: cwnd += mss*mss/cwnd
                  prod_d = {16'd0, mss} * {16'd0, mss};
                  fsm_d  = FSM_GROW_MUL;
                end
              end else begin
                status_c = ST_IGNORED;
                res_load = 1'b1;
              end
            end
            MODE_TIMEOUT: begin
              ssth_d   = half_cwnd;
              cwnd_d   = ({16'd0, mss} < half_cwnd) ? {16'd0, mss} : half_cwnd;
              acked_d  = '0;
              retx_c   = 1'b1;
              status_c = ST_TIMEOUT;
              res_load = 1'b1;
            end
            default: ;
          endcase
        end
      end
      FSM_DIV_CHUNK: begin
        if (div_rsp.done) begin
          status_c  = ST_BURST;
          rbytes_c  = bbytes_q;
          rchunks_c = div_rsp.quotient[15:0];
          res_load  = 1'b1;
          fsm_d     = FSM_IDLE;
        end
      end
      FSM_GROW_MUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = cwnd_q;
        fsm_d            = FSM_DIV_GROW;
      end
      FSM_DIV_GROW: begin
        if (div_rsp.done) begin
          cwnd_d   = sat_add(cwnd_q, div_rsp.quotient);
          status_c = ST_NEW_ACK;
          res_load = 1'b1;
          fsm_d    = FSM_IDLE;
        end
      end
      default: fsm_d = FSM_IDLE;
    endcase
  end

  // result assembled from the post-event state
  always_comb begin
    res_d              = res_q;
    res_valid_d        = res_valid_q && !res_o.ready;
    if (res_load) begin
      res_valid_d        = 1'b1;
      res_d.status       = status_c;
      res_d.burst_bytes  = rbytes_c;
      res_d.burst_chunks = rchunks_c;
      res_d.acked_total  = acked_d;
      res_d.burst_done   = acked_d >= {16'd0, blen_d};
      res_d.retransmit   = retx_c;
      res_d.resend_seq   = bseq_d;
      res_d.cong_window  = cwnd_d;
      res_d.ssthresh     = ssth_d;
      res_d.peer_window  = peer_d;
    end
  end

  tcwc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= SegSizeRst;
      iw_q        <= InitWinRst;
      cwnd_q      <= '0;
      ssth_q      <= '0;
      peer_q      <= '0;
      dup_q       <= '0;
      bseq_q      <= '0;
      blen_q      <= '0;
      acked_q     <= '0;
      fsm_q       <= FSM_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SEGMENT_SIZE:   seg_q <= cfg_data_i[15:0];
          CFG_INITIAL_WINDOW: iw_q  <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      cwnd_q      <= cwnd_d;
      ssth_q      <= ssth_d;
      peer_q      <= peer_d;
      dup_q       <= dup_d;
      bseq_q      <= bseq_d;
      blen_q      <= blen_d;
      acked_q     <= acked_d;
      fsm_q       <= fsm_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    bbytes_q <= bbytes_d;
    prod_q   <= prod_d;
    res_q    <= res_d;
  end

  assign res_o.valid                = res_valid_q;
  assign res_o.status               = res_q.status;
  assign res_o.burst_bytes          = res_q.burst_bytes;
  assign res_o.burst_chunks         = res_q.burst_chunks;
  assign res_o.acked_total          = res_q.acked_total;
  assign res_o.burst_done           = res_q.burst_done;
  assign res_o.retransmit           = res_q.retransmit;
  assign res_o.resend_seq           = res_q.resend_seq;
  assign res_o.cong_window          = res_q.cong_window;
  assign res_o.slow_start_threshold = res_q.ssthresh;
  assign res_o.peer_window_out      = res_q.peer_window;

endmodule
